// ----- rtl/icis_pkg.sv -----
// ----------------------------------------------------------------------------
// icis_pkg
// Shared constants and types for the inverse curve interpolated search block.
// ----------------------------------------------------------------------------
package icis_pkg;

	localparam int MaxPoints    = 256;
	localparam int FractionBits = 16;
	localparam int AddrW        = $clog2(MaxPoints);
	localparam int CountW       = $clog2(MaxPoints + 1);
	localparam int ValueW       = 32;
	localparam int FracW        = 17;
	// dividend widths: |a-d| << F needs 33+F bits, (i<<F)+tq needs AddrW+F+1
	localparam int Div1W        = ValueW + 1 + FractionBits;
	localparam int Div2W        = AddrW + FractionBits + 1;
	localparam int DivW         = (Div1W > Div2W) ? Div1W : Div2W;
	localparam int DivCntW      = $clog2(DivW + 1);

	typedef enum logic {
		KIND_SAMPLE = 1'b0,
		KIND_QUERY  = 1'b1
	} kind_t;

	// request queued from front to back
	typedef struct packed {
		logic                     is_query;
		logic signed [ValueW-1:0] value;
		logic                     restart;
	} req_t;

endpackage

// ----- rtl/icis_front.sv -----
// ----------------------------------------------------------------------------
// icis_front
// Accepts input requests, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module icis_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [39:0]        in_data,
	input  logic               in_user,
	output logic               q_valid,
	input  logic               q_ready,
	output icis_pkg::req_t     q_req
);
	import icis_pkg::*;

	localparam int Depth = 2;

	req_t      fifo_q [Depth];
	logic      wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	logic      push, pop;
	req_t      req_in;

	always_comb begin
		req_in.is_query = (kind_t'(in_user) == KIND_QUERY);
		req_in.value    = signed'(in_data[ValueW-1:0]);
		req_in.restart  = in_data[ValueW];
	end

	assign in_ready = (cnt_q != 2'(Depth));
	assign q_valid  = (cnt_q != 2'd0);
	assign q_req    = fifo_q[rd_ptr_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= req_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

// ----- rtl/icis_div.sv -----
// ----------------------------------------------------------------------------
// icis_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module icis_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [icis_pkg::DivW-1:0]  dividend,
	input  logic [icis_pkg::DivW-1:0]  divisor,
	output logic                       done,
	output logic [icis_pkg::DivW-1:0]  quotient
);
	import icis_pkg::*;

	logic [DivW-1:0]    quo_q, dsr_q;
	logic [DivW:0]      rem_q;
	logic [DivCntW-1:0] cnt_q;
	logic               busy_q;
	logic [DivW:0]      trial;
	logic [DivW:0]      shifted;

	assign shifted  = {rem_q[DivW-1:0], quo_q[DivW-1]};
	assign trial    = shifted - {1'b0, dsr_q};
	assign quotient = quo_q;

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!trial[DivW]) begin
				rem_q <= trial;
				quo_q <= {quo_q[DivW-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[DivW-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DivCntW'(DivW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DivCntW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

endmodule

// ----- rtl/icis_back.sv -----
// ----------------------------------------------------------------------------
// icis_back
// Curve store, bracket scan and interpolation sequencer with output register.
// ----------------------------------------------------------------------------
module icis_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	output logic           q_ready,
	input  icis_pkg::req_t q_req,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [23:0]    out_data,
	output logic [1:0]     out_user
);
	import icis_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_RD0   = 7'b0000010,
		ST_SCAN  = 7'b0000100,
		ST_DIV1  = 7'b0001000,
		ST_DIV2  = 7'b0010000,
		ST_WAIT2 = 7'b0100000,
		ST_OUT   = 7'b1000000
	} state_t;

	state_t state_q;

	logic signed [ValueW-1:0] mem [MaxPoints];
	logic signed [ValueW-1:0] rd_data_q;
	logic [AddrW-1:0]         rd_addr;
	logic                     rd_en;

	logic [CountW-1:0]        count_q;
	logic                     dropped_q;
	logic signed [ValueW-1:0] d_q, first_q, prev_q;
	logic [AddrW-1:0]         idx_q;       // index of segment start (prev)
	logic [CountW-1:0]        rd_idx_q;    // next address to read
	logic                     have_prev_q;
	logic [FracW-1:0]         frac_q;
	logic                     found_q;
	logic [DivW-1:0]          tq_q;

	logic                     div_start, div_done;
	logic [DivW-1:0]          div_dividend, div_divisor, div_quo;

	icis_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	logic signed [ValueW:0] a_x, b_x, d_x;
	logic [ValueW:0]        span, d_off;
	logic                   bracket;
	assign a_x   = ValueW'(0) + prev_q;
	assign b_x   = rd_data_q;
	assign d_x   = d_q;
	assign span  = (a_x >= b_x) ? unsigned'(a_x - b_x) : unsigned'(b_x - a_x);
	assign d_off = (a_x >= d_x) ? unsigned'(a_x - d_x) : unsigned'(d_x - a_x);
	assign bracket = (d_x <= a_x && d_x >= b_x) || (d_x >= a_x && d_x <= b_x);

	assign q_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk) begin
		if (q_valid && q_ready && !q_req.is_query && (q_req.restart ||
				count_q < CountW'(MaxPoints))) begin
			mem[q_req.restart ? AddrW'(0) : count_q[AddrW-1:0]] <= q_req.value;
		end
		if (rd_en) rd_data_q <= mem[rd_addr];
	end

	assign rd_addr = rd_idx_q[AddrW-1:0];
	assign rd_en   = (state_q == ST_RD0) || (state_q == ST_SCAN);

	always_comb begin
		div_start    = 1'b0;
		div_dividend = '0;
		div_divisor  = '0;
		if (state_q == ST_SCAN && have_prev_q && bracket) begin
			div_start    = (span != '0);
			div_dividend = DivW'({d_off, FractionBits'(0)});
			div_divisor  = DivW'(span);
		end else if (state_q == ST_DIV2) begin
			div_start    = 1'b1;
			div_dividend = DivW'({idx_q, FractionBits'(0)}) + tq_q;
			div_divisor  = DivW'(count_q - 1'b1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			dropped_q   <= 1'b0;
			out_valid   <= 1'b0;
			out_data    <= '0;
			out_user    <= '0;
			have_prev_q <= 1'b0;
			d_q         <= '0;
			first_q     <= '0;
			prev_q      <= '0;
			idx_q       <= '0;
			rd_idx_q    <= '0;
			frac_q      <= '0;
			found_q     <= 1'b0;
			tq_q        <= '0;
		end else begin
			// ST_OUT handles out_valid itself
			if (out_valid && out_ready && state_q != ST_OUT) out_valid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						if (!q_req.is_query) begin
							if (q_req.restart) begin
								count_q   <= CountW'(1);
								dropped_q <= 1'b0;
							end else if (count_q < CountW'(MaxPoints)) begin
								count_q <= count_q + 1'b1;
							end else begin
								dropped_q <= 1'b1;
							end
						end else begin
							d_q      <= q_req.value;
							found_q  <= 1'b0;
							frac_q   <= '0;
							rd_idx_q <= '0;
							have_prev_q <= 1'b0;
							state_q  <= (count_q == '0) ? ST_OUT : ST_RD0;
						end
					end
				end
				ST_RD0: begin
					rd_idx_q <= rd_idx_q + 1'b1;
					idx_q    <= '0;
					state_q  <= ST_SCAN;
				end
				ST_SCAN: begin
					// rd_data_q holds entry rd_idx_q-1
					if (!have_prev_q) begin
						first_q     <= rd_data_q;
						prev_q      <= rd_data_q;
						have_prev_q <= 1'b1;
						if (rd_idx_q >= count_q) begin
							frac_q  <= (d_q > rd_data_q) ? '0 : FracW'(1 << FractionBits);
							state_q <= ST_OUT;
						end else begin
							rd_idx_q <= rd_idx_q + 1'b1;
						end
					end else if (bracket) begin
						found_q <= 1'b1;
						if (span == '0) begin
							tq_q    <= '0;
							state_q <= ST_DIV2;
						end else begin
							state_q <= ST_DIV1;
						end
					end else if (rd_idx_q >= count_q) begin
						frac_q  <= (d_q > first_q) ? '0 : FracW'(1 << FractionBits);
						state_q <= ST_OUT;
					end else begin
						prev_q   <= rd_data_q;
						idx_q    <= idx_q + 1'b1;
						rd_idx_q <= rd_idx_q + 1'b1;
					end
				end
				ST_DIV1: begin
					if (div_done) begin
						tq_q    <= div_quo;
						state_q <= ST_DIV2;
					end
				end
				ST_DIV2: state_q <= ST_WAIT2;
				ST_WAIT2: begin
					if (div_done) begin
						frac_q  <= div_quo[FracW-1:0];
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!out_valid || out_ready) begin
						out_valid <= 1'b1;
						out_data  <= {7'b0, frac_q};
						out_user  <= {dropped_q, found_q};
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/inverse_curve_interpolated_search_top.sv -----
// ----------------------------------------------------------------------------
// inverse_curve_interpolated_search_top
// Stores a sampled curve and answers inverse lookups by interpolation.
// ----------------------------------------------------------------------------
// A sample request is written to the curve memory while the back end is idle.
// A query scans the stored samples one per cycle from the curve memory, then
// runs up to two divisions on a shared bit-serial divider. A two-entry request
// queue lets new requests arrive while a query is running.
module inverse_curve_interpolated_search_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // [31:0] value, [32] restart
	input  logic        s_axis_tuser,  // [0] kind
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // [16:0] time_fraction
	output logic [1:0]  m_axis_tuser   // [0] bracket_found, [1] overflowed
);
	import icis_pkg::*;

	logic q_valid, q_ready;
	req_t q_req;

	icis_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_data  (s_axis_tdata),
		.in_user  (s_axis_tuser),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_req    (q_req)
	);

	icis_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_req     (q_req),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_user  (m_axis_tuser)
	);

endmodule

// ----- rtl/icis_checker.sv -----
// ----------------------------------------------------------------------------
// icis_checker
// Port-level checks on the inverse curve search block.
// ----------------------------------------------------------------------------
module icis_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser
);
	// fraction never exceeds 1.0
	a_frac_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[16:0] <= 17'h10000)
		else $error("fraction above one");

	// fallback answers are either 0 or 1.0
	a_fallback: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser[0]) |->
		(m_axis_tdata[16:0] == 17'h0 || m_axis_tdata[16:0] == 17'h10000))
		else $error("fallback value");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[23:17] == 7'h0)
		else $error("pad bits set");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
		else $error("stalled result changed");

endmodule

bind inverse_curve_interpolated_search_top icis_checker u_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
